// ===== hw/rtl/oel_pkg.sv =====
// Package for the ordered entry list: request and response types, codes,
// controller states and the command and status bundles between the two halves.
// No dependencies.
`default_nettype none

package oel_pkg;

  // Default number of entries the list can hold.
  localparam int unsigned OEL_CAPACITY_DEF = 16;

  // Width of one stored entry: a two-bit tag above an eight-bit value.
  localparam int unsigned ENTRY_W = 10;

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_REM_LAST  = 2'd2,
    OP_REM_MATCH = 2'd3
  } oel_op_e;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } oel_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } oel_state_e;

  typedef struct packed {
    oel_op_e    operation;
    logic [7:0] entry_value;
    logic [1:0] entry_tag;
  } oel_req_t;

  typedef struct packed {
    oel_status_e status;
    logic [4:0]  entry_count;
  } oel_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        latch_req;  // capture the request for a search
    logic        push_front; // write the request entry before the head
    logic        push_back;  // write the request entry after the tail
    logic        count_dec;  // drop one entry from the count
    logic        pos_clr;    // restart the position counter
    logic        pos_inc;    // advance the position counter
    logic        rd_en;      // read the memory
    logic        rd_next;    // read one position past the counter
    logic        wr_shift;   // write the read data back at the counter
    logic        finish;     // present a response
    oel_status_e fin_status;
  } oel_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_at_end;
    logic next_at_end;
    logic match;
  } oel_stat_t;

endpackage : oel_pkg

`default_nettype wire

// ===== hw/rtl/oel_ctrl.sv =====
// Controller of the ordered entry list: sequences searches and gap closing.
// Depends on oel_pkg.
`default_nettype none

module oel_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire oel_pkg::oel_op_e  op_i,
  input  wire oel_pkg::oel_stat_t stat_i,
  output oel_pkg::oel_cmd_t      cmd_o,
  output logic                   busy_o
);
  import oel_pkg::*;

  oel_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start && (op_i == OP_REM_MATCH)) state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_d = stat_i.pos_at_end ? S_IDLE : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        state_d = stat_i.match ? S_SHIFT_RD : S_SCAN_RD;
      end
      S_SHIFT_RD: begin
        state_d = stat_i.next_at_end ? S_IDLE : S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_d = S_SHIFT_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    cmd_o.fin_status = STATUS_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (op_i)
            OP_INS_FRONT: begin
              cmd_o.finish = 1'b1;
              if (stat_i.full) cmd_o.fin_status = STATUS_FULL;
              else cmd_o.push_front = 1'b1;
            end
            OP_INS_BACK: begin
              cmd_o.finish = 1'b1;
              if (stat_i.full) cmd_o.fin_status = STATUS_FULL;
              else cmd_o.push_back = 1'b1;
            end
            OP_REM_LAST: begin
              cmd_o.finish = 1'b1;
              if (stat_i.empty) cmd_o.fin_status = STATUS_MISS;
              else cmd_o.count_dec = 1'b1;
            end
            OP_REM_MATCH: begin
              cmd_o.latch_req = 1'b1;
              cmd_o.pos_clr   = 1'b1;
            end
            default: cmd_o = '0;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (stat_i.pos_at_end) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = STATUS_MISS;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      S_SCAN_CMP: begin
        // The position stays on the match; the gap is closed from there.
        if (!stat_i.match) cmd_o.pos_inc = 1'b1;
      end
      S_SHIFT_RD: begin
        if (stat_i.next_at_end) begin
          cmd_o.count_dec = 1'b1;
          cmd_o.finish    = 1'b1;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.pos_inc  = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule : oel_ctrl

`default_nettype wire

// ===== hw/rtl/oel_datapath.sv =====
// Datapath of the ordered entry list: circular entry memory, head pointer,
// count, position counter and the registered response. Depends on oel_pkg.
`default_nettype none

module oel_datapath #(
  parameter int unsigned CAPACITY = oel_pkg::OEL_CAPACITY_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire oel_pkg::oel_req_t  req_i,
  input  wire oel_pkg::oel_cmd_t  cmd_i,
  output oel_pkg::oel_stat_t      stat_o,
  output logic                    done_o,
  output oel_pkg::oel_rsp_t       rsp_o
);
  import oel_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned EXT_W = CNT_W + 5;

  // Logical position to memory address, with the wrap past the last entry.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(pos);
    if (sum >= SUM_W'(CAPACITY)) sum = sum - SUM_W'(CAPACITY);
    return IDX_W'(sum);
  endfunction

  logic [ENTRY_W-1:0] mem_q [CAPACITY];
  logic [ENTRY_W-1:0] rd_data_q;
  logic [IDX_W-1:0]   head_q, head_d, head_m1;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   pos_q, pos_d, rd_pos;
  oel_req_t           req_q;
  logic               done_q;
  oel_rsp_t           rsp_q, rsp_d;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               wr_en;
  logic [EXT_W-1:0]   count_ext;

  assign head_m1 = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - 1'b1;

  // Head, count and position updates.
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    if (cmd_i.push_front) head_d = head_m1;
    if (cmd_i.push_front || cmd_i.push_back) count_d = count_q + 1'b1;
    if (cmd_i.count_dec) count_d = count_q - 1'b1;
    if (cmd_i.pos_clr) pos_d = '0;
    if (cmd_i.pos_inc) pos_d = pos_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      done_q  <= cmd_i.finish;
    end
  end

  // Request capture for searches, and the response register.
  assign count_ext         = EXT_W'(count_d);
  assign rsp_d.status      = cmd_i.fin_status;
  assign rsp_d.entry_count = count_ext[4:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) req_q <= req_i;
    if (cmd_i.finish) rsp_q <= rsp_d;
  end

  // Memory port selection: inserts come straight from the request.
  always_comb begin
    wr_en   = cmd_i.push_front || cmd_i.push_back || cmd_i.wr_shift;
    wr_addr = phys(head_q, pos_q);
    wr_data = rd_data_q;
    if (cmd_i.push_front) begin
      wr_addr = head_m1;
      wr_data = {req_i.entry_tag, req_i.entry_value};
    end else if (cmd_i.push_back) begin
      wr_addr = phys(head_q, count_q);
      wr_data = {req_i.entry_tag, req_i.entry_value};
    end
  end

  assign rd_pos  = cmd_i.rd_next ? pos_q + 1'b1 : pos_q;
  assign rd_addr = phys(head_q, rd_pos);

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_data_q <= mem_q[rd_addr];
  end

  // Status toward the controller.
  assign stat_o.full        = (count_q == CNT_W'(CAPACITY));
  assign stat_o.empty       = (count_q == '0);
  assign stat_o.pos_at_end  = (pos_q == count_q);
  assign stat_o.next_at_end = ((SUM_W'(pos_q) + 1'b1) >= SUM_W'(count_q));
  assign stat_o.match       = (rd_data_q == {req_q.entry_tag, req_q.entry_value});

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule : oel_datapath

`default_nettype wire

// ===== hw/rtl/ordered_entry_list_top.sv =====
// Ordered entry list, top level. Insert front, insert back and remove last
// leave busy low, and the result strobe follows in the next cycle. Remove
// matching keeps busy high while it walks the list through the single read
// port of the entry memory, first scanning and then closing the gap; the result
// strobe comes in the same cycle that busy falls. The receiver cannot stall.
// Reset empties the list; the entry memory itself is not cleared.
`default_nettype none

module ordered_entry_list_top #(
  parameter int unsigned CAPACITY = oel_pkg::OEL_CAPACITY_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire oel_pkg::oel_req_t req_i,
  output logic                   done_o,
  output oel_pkg::oel_rsp_t      rsp_o
);
  import oel_pkg::*;

  oel_cmd_t  cmd;
  oel_stat_t stat;
  logic      ctrl_busy;

  // Controller.
  oel_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (req_i.operation),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (ctrl_busy)
  );

  // Datapath.
  oel_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  assign busy = ctrl_busy;

  // Requests other than remove matching answer in the next cycle.
  a_quick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation != OP_REM_MATCH)) |=> done_o)
    else $error("single-cycle request gave no result");

  // A search always ends with a result.
  a_search_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("search ended without a result");

  // A full flag only answers a request accepted in the cycle before.
  a_full_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == STATUS_FULL)) |-> $past(start && !busy))
    else $error("full status without an accepted insert");

endmodule : ordered_entry_list_top

`default_nettype wire

// ===== tb/oel_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ordered entry list: watches the request and result channels,
// predicts every result from its own copy of the list and compares field by field.
// Depends on oel_pkg for the request, result, operation and status types.

module oel_list_checker
  import oel_pkg::*;
#(
  parameter int unsigned CAPACITY = OEL_CAPACITY_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire logic     busy,
  input  wire oel_req_t req_i,
  input  wire logic     done_o,
  input  wire oel_rsp_t rsp_o,
  output int            fail_count_o,
  output int            pending_o
);

  localparam int unsigned REPORT_MAX = 10;

  // Shadow copy of the list: position 0 is the front, tag above value.
  logic [ENTRY_W-1:0] shadow_entries[CAPACITY];
  int                 shadow_count;

  // Results owed by the block, oldest first.
  oel_rsp_t           owed_rsp_q[$];
  oel_rsp_t           want_rsp;

  initial begin
    shadow_count = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Apply one request to the shadow list and return the result it should give.
  function automatic oel_rsp_t apply_list_request(input oel_req_t r);
    logic [ENTRY_W-1:0] key;
    int                 hit;
    int                 i;
    oel_rsp_t           rsp;
    key        = {r.entry_tag, r.entry_value};
    rsp.status = STATUS_DONE;
    hit        = -1;
    case (r.operation)
      OP_INS_FRONT: begin
        if (shadow_count >= CAPACITY) begin
          rsp.status = STATUS_FULL;
        end else begin
          for (i = shadow_count; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = key;
          shadow_count++;
        end
      end
      OP_INS_BACK: begin
        if (shadow_count >= CAPACITY) begin
          rsp.status = STATUS_FULL;
        end else begin
          shadow_entries[shadow_count] = key;
          shadow_count++;
        end
      end
      OP_REM_LAST: begin
        if (shadow_count == 0) rsp.status = STATUS_MISS;
        else shadow_count--;
      end
      default: begin
        // Only the matching entry nearest the front goes; the rest close up.
        for (i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_entries[i] == key) hit = i;
        end
        if (hit < 0) begin
          rsp.status = STATUS_MISS;
        end else begin
          for (i = hit; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
    endcase
    rsp.entry_count = 5'(shadow_count);
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    if (fail_count_o < REPORT_MAX) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
    fail_count_o++;
  endtask

  // Results are compared before a request of the same edge is predicted, since a
  // request accepted now can only produce its result in a later cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (owed_rsp_q.size() == 0) begin
          report_mismatch("unexpected result, status", -1, int'(rsp_o.status));
        end else begin
          want_rsp = owed_rsp_q.pop_front();
          if (rsp_o.status !== want_rsp.status) begin
            report_mismatch("status", int'(want_rsp.status), int'(rsp_o.status));
          end
          if (rsp_o.entry_count !== want_rsp.entry_count) begin
            report_mismatch("entry_count", int'(want_rsp.entry_count),
                            int'(rsp_o.entry_count));
          end
        end
      end
      if (start && !busy) begin
        owed_rsp_q.push_back(apply_list_request(req_i));
      end
      pending_o = owed_rsp_q.size();
    end
  end

endmodule

// ===== tb/ordered_entry_list_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the ordered entry list: clock, reset, directed and random
// requests, watchdog and verdict. Depends on oel_pkg, ordered_entry_list_top and
// oel_list_checker.

module ordered_entry_list_top_tb;
  import oel_pkg::*;

  localparam int unsigned CAPACITY   = OEL_CAPACITY_DEF;
  localparam int          PHASES     = 23;
  localparam int          PHASE_LEN  = 50;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          DRAIN_WAIT = 40;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  oel_req_t req_i;
  logic     done_o;
  oel_rsp_t rsp_o;

  int         fail_count;
  int         pending;
  int         idle_cycles;
  bit         back_to_back;
  logic [7:0] key_pool[4];

  ordered_entry_list_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  oel_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: ends the run when neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request from a falling edge and hold it until it is taken,
  // then idle for a drawn number of cycles unless in a back-to-back stretch.
  task automatic issue_request(input oel_op_e op, input logic [7:0] value,
                               input logic [1:0] tag);
    oel_req_t r;
    bit       taken;
    int       gap;
    r.operation   = op;
    r.entry_value = value;
    r.entry_tag   = tag;
    taken         = 1'b0;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
    gap = back_to_back ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stop sending until every owed result has come back.
  task automatic wait_list_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // One random request shaped by the phase: fill, drain or balanced.
  task automatic random_request(input int insert_pct);
    oel_op_e    op;
    logic [7:0] value;
    if ($urandom_range(0, 99) < 10) begin
      // Noise: any operation with any key.
      op    = oel_op_e'($urandom_range(0, 3));
      value = 8'($urandom_range(0, 255));
    end else begin
      if ($urandom_range(0, 99) < insert_pct) begin
        op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_REM_LAST : OP_REM_MATCH;
      end
      // A small key pool makes matches and duplicates common.
      value = key_pool[$urandom_range(0, 3)];
    end
    issue_request(op, value, 2'($urandom_range(0, 3)));
  endtask

  initial begin
    int i;
    int ph;
    int insert_pct;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    idle_cycles  = 0;
    back_to_back = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: removes on an empty list, a fill to capacity with extreme keys and
    // a duplicate, inserts when full, then matching by value and tag.
    issue_request(OP_REM_LAST, 8'h00, 2'd0);
    issue_request(OP_REM_MATCH, 8'hFF, 2'd3);
    for (i = 0; i < CAPACITY; i++) begin
      case (i)
        0:       issue_request(OP_INS_FRONT, 8'h00, 2'd0);
        1:       issue_request(OP_INS_BACK, 8'hFF, 2'd3);
        2, 3:    issue_request(i[0] ? OP_INS_BACK : OP_INS_FRONT, 8'h5A, 2'd1);
        default: issue_request(i[0] ? OP_INS_BACK : OP_INS_FRONT, 8'(i * 17), 2'(i));
      endcase
    end
    issue_request(OP_INS_FRONT, 8'hA5, 2'd2);
    issue_request(OP_INS_BACK, 8'hA5, 2'd2);
    issue_request(OP_REM_MATCH, 8'h5A, 2'd1);
    issue_request(OP_REM_MATCH, 8'hFF, 2'd0);
    issue_request(OP_REM_MATCH, 8'h00, 2'd0);
    issue_request(OP_REM_LAST, 8'h00, 2'd0);
    wait_list_idle();

    // Random phases cycling through fill, drain and balanced mixes.
    for (ph = 0; ph < PHASES; ph++) begin
      for (i = 0; i < 4; i++) key_pool[i] = 8'($urandom_range(0, 255));
      back_to_back = ($urandom_range(0, 2) == 0);
      case (ph % 3)
        0:       insert_pct = 70;
        1:       insert_pct = 30;
        default: insert_pct = 50;
      endcase
      for (i = 0; i < PHASE_LEN; i++) random_request(insert_pct);
      if (ph % 5 == 4) wait_list_idle();
    end

    wait_list_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
